FILE: rtl/cpu6502_alu_branch_brk_unit_top_macros.svh
// Assertion macros for the 6502 ALU/branch/BRK unit checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef CPU6502_ALU_BRANCH_BRK_UNIT_TOP_MACROS_SVH
`define CPU6502_ALU_BRANCH_BRK_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define C6502_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C6502_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/c6502_pkg.sv
// Shared types and constants for the 6502 ALU/branch/BRK unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c6502_pkg;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 64;

    localparam logic [2:0] REQ_ADC   = 3'd0;
    localparam logic [2:0] REQ_AND   = 3'd1;
    localparam logic [2:0] REQ_ASL_A = 3'd2;
    localparam logic [2:0] REQ_ASL_M = 3'd3;
    localparam logic [2:0] REQ_BIT   = 3'd4;
    localparam logic [2:0] REQ_BRA   = 3'd5;
    localparam logic [2:0] REQ_BRK   = 3'd6;

    localparam logic [2:0] COND_BPL = 3'd0;
    localparam logic [2:0] COND_BMI = 3'd1;
    localparam logic [2:0] COND_BCC = 3'd2;
    localparam logic [2:0] COND_BCS = 3'd3;
    localparam logic [2:0] COND_BNE = 3'd4;
    localparam logic [2:0] COND_BEQ = 3'd5;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] ACC_RESET    = 8'h00;
    localparam logic [7:0] STATUS_RESET = 8'h24;
    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STACK_PAGE   = 8'h01;

    localparam logic [1:0] BRK_IDLE  = 2'd0;
    localparam logic [1:0] BRK_LAST  = 2'd1;
    localparam logic [1:0] BRK_LOW   = 2'd2;

    typedef struct packed {
        logic        mem_write;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  acc_out;
        logic [7:0]  status_out;
        logic [15:0] next_pc;
        logic [1:0]  extra_cycles;
        logic        last_of_run;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/cpu6502_alu_branch_brk_unit_top.sv
// Top level of the 6502 ALU/branch/BRK unit: state, result register, BRK sequencer.
// Depends on c6502_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                                   tuser      tlast
// s_axis    in   operand,address,branch_cond,offset,pc   req_type   -
// m_axis    out  mem_addr,mem_data,acc,status,npc,extra  mem_write  last_of_run
// cfg       in   cfg_wr_data = irq_vector (cfg_wr_en)    -          -
//
// One input per cycle unless stalled or in BRK; results are registered at acceptance.
// BRK gives three output transfers; input is held off until the last is loaded.
// Output register frees and refills in the same cycle, so a stall only waits on m_axis_tready.
// Reset: A = 00, P = 24, S = FD, irq_vector = 0000, output empty.

module cpu6502_alu_branch_brk_unit_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] operand, [23:8] address, [26:24] branch_cond, [34:27] branch_offset,
    // [50:35] pc_now, [55:51] zero
    input  wire logic [c6502_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [2:0] req_type
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] mem_addr, [23:16] mem_data, [31:24] acc_out, [39:32] status_out,
    // [55:40] next_pc, [57:56] extra_cycles, [63:58] zero
    output logic [c6502_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] mem_write
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  sp_reg, sp_next;
    logic [15:0] irq_vector_reg;
    logic        out_valid_reg, out_valid_next;
    c6502_pkg::res_t out_reg, out_next;
    logic [1:0]  brk_left_reg, brk_left_next;
    logic [7:0]  brk_lo_reg, brk_lo_next;
    logic [7:0]  brk_psr_reg, brk_psr_next;
    logic [7:0]  brk_sp_reg, brk_sp_next;

    logic        s_xfer;
    logic        out_free;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [2:0]  branch_cond;
    logic [7:0]  branch_offset;
    logic [15:0] pc_now;
    logic [8:0]  sum;
    logic [7:0]  alu_r;
    logic        take;
    logic [15:0] target;
    logic [15:0] ret_pc;
    c6502_pkg::res_t res;

    assign operand       = s_axis_tdata[7:0];
    assign address       = s_axis_tdata[23:8];
    assign branch_cond   = s_axis_tdata[26:24];
    assign branch_offset = s_axis_tdata[34:27];
    assign pc_now        = s_axis_tdata[50:35];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (brk_left_reg == c6502_pkg::BRK_IDLE) && out_free;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign sum    = {1'b0, acc_reg} + {1'b0, operand} + {8'd0, status_reg[c6502_pkg::FLAG_C]};
    assign target = pc_now + {{8{branch_offset[7]}}, branch_offset};
    assign ret_pc = pc_now + 16'd1;

    always_comb
    begin
        take = 1'b0;
        case (branch_cond)
            c6502_pkg::COND_BPL: take = !status_reg[c6502_pkg::FLAG_N];
            c6502_pkg::COND_BMI: take =  status_reg[c6502_pkg::FLAG_N];
            c6502_pkg::COND_BCC: take = !status_reg[c6502_pkg::FLAG_C];
            c6502_pkg::COND_BCS: take =  status_reg[c6502_pkg::FLAG_C];
            c6502_pkg::COND_BNE: take = !status_reg[c6502_pkg::FLAG_Z];
            c6502_pkg::COND_BEQ: take =  status_reg[c6502_pkg::FLAG_Z];
            default:             take = 1'b0;
        endcase
    end

    // one item: next architectural state and first result
    always_comb
    begin
        acc_next     = acc_reg;
        status_next  = status_reg;
        sp_next      = sp_reg;
        alu_r        = 8'd0;
        brk_lo_next  = brk_lo_reg;
        brk_psr_next = brk_psr_reg;
        res.mem_write    = 1'b0;
        res.mem_addr     = 16'd0;
        res.mem_data     = 8'd0;
        res.next_pc      = pc_now;
        res.extra_cycles = 2'd0;
        res.last_of_run  = 1'b1;
        case (s_axis_tuser)
            c6502_pkg::REQ_ADC:
            begin
                alu_r = sum[7:0];
                acc_next = alu_r;
                status_next[c6502_pkg::FLAG_C] = sum[8];
                status_next[c6502_pkg::FLAG_V] = ~(acc_reg[7] ^ operand[7]) & (acc_reg[7] ^ alu_r[7]);
                status_next[c6502_pkg::FLAG_Z] = (alu_r == 8'd0);
                status_next[c6502_pkg::FLAG_N] = alu_r[7];
            end
            c6502_pkg::REQ_AND:
            begin
                alu_r = acc_reg & operand;
                acc_next = alu_r;
                status_next[c6502_pkg::FLAG_Z] = (alu_r == 8'd0);
                status_next[c6502_pkg::FLAG_N] = alu_r[7];
            end
            c6502_pkg::REQ_ASL_A:
            begin
                alu_r = {acc_reg[6:0], 1'b0};
                acc_next = alu_r;
                status_next[c6502_pkg::FLAG_C] = acc_reg[7];
                status_next[c6502_pkg::FLAG_Z] = (alu_r == 8'd0);
                status_next[c6502_pkg::FLAG_N] = alu_r[7];
            end
            c6502_pkg::REQ_ASL_M:
            begin
                alu_r = {operand[6:0], 1'b0};
                status_next[c6502_pkg::FLAG_C] = operand[7];
                status_next[c6502_pkg::FLAG_Z] = (alu_r == 8'd0);
                status_next[c6502_pkg::FLAG_N] = alu_r[7];
                res.mem_write = 1'b1;
                res.mem_addr  = address;
                res.mem_data  = alu_r;
            end
            c6502_pkg::REQ_BIT:
            begin
                status_next[c6502_pkg::FLAG_Z] = ((acc_reg & operand) == 8'd0);
                status_next[c6502_pkg::FLAG_V] = operand[6];
                status_next[c6502_pkg::FLAG_N] = operand[7];
            end
            c6502_pkg::REQ_BRA:
            begin
                if (take)
                begin
                    res.next_pc      = target;
                    res.extra_cycles = (pc_now[15:8] != target[15:8]) ? 2'd2 : 2'd1;
                end
            end
            c6502_pkg::REQ_BRK:
            begin
                // pushes PC+1 high, PC+1 low, then P with B and unused set
                sp_next      = sp_reg - 8'd3;
                brk_lo_next  = ret_pc[7:0];
                brk_psr_next = status_reg | 8'h30;
                status_next  = (status_reg | 8'h24) & 8'hEF;
                res.mem_write   = 1'b1;
                res.mem_addr    = {c6502_pkg::STACK_PAGE, sp_reg};
                res.mem_data    = ret_pc[15:8];
                res.next_pc     = irq_vector_reg;
                res.last_of_run = 1'b0;
            end
            default:
            begin
                res.next_pc = pc_now;
            end
        endcase
        res.acc_out    = acc_next;
        res.status_out = status_next;
    end

    // output register and BRK push sequencer
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        brk_left_next  = brk_left_reg;
        brk_sp_next    = brk_sp_reg;
        if (out_free)
        begin
            if (brk_left_reg == c6502_pkg::BRK_LOW)
            begin
                out_next.mem_addr    = {c6502_pkg::STACK_PAGE, brk_sp_reg};
                out_next.mem_data    = brk_lo_reg;
                out_next.last_of_run = 1'b0;
                out_valid_next       = 1'b1;
                brk_sp_next          = brk_sp_reg - 8'd1;
                brk_left_next        = c6502_pkg::BRK_LAST;
            end
            else if (brk_left_reg == c6502_pkg::BRK_LAST)
            begin
                out_next.mem_addr    = {c6502_pkg::STACK_PAGE, brk_sp_reg};
                out_next.mem_data    = brk_psr_reg;
                out_next.last_of_run = 1'b1;
                out_valid_next       = 1'b1;
                brk_left_next        = c6502_pkg::BRK_IDLE;
            end
            else if (s_xfer)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                if (s_axis_tuser == c6502_pkg::REQ_BRK)
                begin
                    brk_left_next = c6502_pkg::BRK_LOW;
                    brk_sp_next   = sp_reg - 8'd1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= c6502_pkg::ACC_RESET;
            status_reg     <= c6502_pkg::STATUS_RESET;
            sp_reg         <= c6502_pkg::SP_RESET;
            irq_vector_reg <= 16'd0;
            out_valid_reg  <= 1'b0;
            brk_left_reg   <= c6502_pkg::BRK_IDLE;
        end
        else
        begin
            if (s_xfer)
            begin
                acc_reg    <= acc_next;
                status_reg <= status_next;
                sp_reg     <= sp_next;
            end
            if (cfg_wr_en)
            begin
                irq_vector_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
            brk_left_reg  <= brk_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        brk_sp_reg  <= brk_sp_next;
        if (s_xfer)
        begin
            brk_lo_reg  <= brk_lo_next;
            brk_psr_reg <= brk_psr_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.extra_cycles, out_reg.next_pc, out_reg.status_out,
                            out_reg.acc_out, out_reg.mem_data, out_reg.mem_addr};
    assign m_axis_tuser  = out_reg.mem_write;
    assign m_axis_tlast  = out_reg.last_of_run;

endmodule

`default_nettype wire

FILE: rtl/c6502_chk.sv
// Port-level checker for the 6502 ALU/branch/BRK unit, bound to the top level.
// Depends on c6502_pkg and cpu6502_alu_branch_brk_unit_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cpu6502_alu_branch_brk_unit_top_macros.svh"

module c6502_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [c6502_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // stalled result holds
    `C6502_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // BRK pushes follow without a gap in valid
    `C6502_ASSERT_NEXT(a_brk_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "BRK push sequence broken")

    // only BRK pushes are non-final, and they always write
    `C6502_ASSERT_IMPL(a_brk_write, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0] && m_axis_tdata[15:8] == 8'h01, "non-final result without stack write")

    // no new item while pushes are still outstanding
    `C6502_ASSERT_IMPL(a_brk_block, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input taken during BRK pushes")

    // extra_cycles field never holds 2'b11
    `C6502_ASSERT_IMPL(a_extra_rng, m_axis_tvalid, m_axis_tdata[57:56] != 2'b11, "extra_cycles out of range")

endmodule

bind cpu6502_alu_branch_brk_unit_top c6502_chk u_c6502_chk (.*);

`default_nettype wire
